>>> sv/csfw_pkg.sv
// shared types and constants for the counting semaphore with fifo wait queue
// no dependencies
package csfw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int PID_W  = 8;
  localparam int INIT_W = 8;
  localparam int VAL_W  = 16;

  localparam logic CMD_WAIT   = 1'b0;
  localparam logic CMD_SIGNAL = 1'b1;

  localparam logic signed [VAL_W-1:0] BAL_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] BAL_MAX = 16'sh7fff;
  localparam logic [INIT_W-1:0]       INIT_RESET = 8'd1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

>>> sv/csfw_ctrl.sv
// controller fsm: takes an item, executes it and manages the output register valid
// depends on csfw_pkg
module csfw_ctrl
  import csfw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    in_stall       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_nxt      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          dp_cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/csfw_dp.sv
// datapath: balance, wait ring memory with head/tail/count, result register
// depends on csfw_pkg
module csfw_dp
  import csfw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 dp_cmd,
  input  logic                    cfg_wr_en,
  input  logic [INIT_W-1:0]       cfg_wr_data,
  input  logic                    in_command,
  input  logic [PID_W-1:0]        in_process_id,
  output logic                    out_blocked,
  output logic                    out_woken_valid,
  output logic [PID_W-1:0]        out_woken_id,
  output logic                    out_error_flag,
  output logic signed [VAL_W-1:0] out_semaphore_value
);

  logic [ID_BITS-1:0] ring_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;

  logic [INIT_W-1:0]       init_r;
  logic signed [VAL_W-1:0] bal_r, bal_nxt;
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic               cmd_r;
  logic [ID_BITS-1:0] pid_r;

  logic                    push, pop, err;
  logic signed [VAL_W:0]   val, new_val;
  logic signed [VAL_W-1:0] val_clamped;

  logic                    blocked_r, woken_valid_r, error_r;
  logic [PID_W-1:0]        woken_id_r;
  logic signed [VAL_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= INIT_RESET;
      bal_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        init_r <= cfg_wr_data;
      end
      if (dp_cmd.commit) begin
        bal_r   <= bal_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // ring storage, registered read at the head
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && push) begin
      ring_mem[tail_r] <= pid_r;
    end
    rd_data_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r <= in_command;
      pid_r <= ID_BITS'(in_process_id);
    end
  end

  always_comb begin
    val       = $signed({1'b0, VAL_W'(init_r)}) + {bal_r[VAL_W-1], bal_r};
    bal_nxt   = bal_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    push      = 1'b0;
    pop       = 1'b0;
    err       = 1'b0;
    case (cmd_r)
      CMD_WAIT: begin
        if (bal_r == BAL_MIN) begin
          err = 1'b1;
        end else if (val[VAL_W] || val == '0) begin
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            err = 1'b1;
          end else begin
            push      = 1'b1;
            bal_nxt   = bal_r - 16'sd1;
            tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
            count_nxt = count_r + CNT_W'(1);
          end
        end else begin
          bal_nxt = bal_r - 16'sd1;
        end
      end
      CMD_SIGNAL: begin
        if (bal_r == BAL_MAX) begin
          err = 1'b1;
        end else begin
          bal_nxt = bal_r + 16'sd1;
          // value after the raise is zero or below when the old value was negative
          if (val[VAL_W] && count_r != '0) begin
            pop       = 1'b1;
            head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        err = 1'b0;
      end
    endcase
    new_val = $signed({1'b0, VAL_W'(init_r)}) + {bal_nxt[VAL_W-1], bal_nxt};
    if (new_val > $signed({1'b0, BAL_MAX})) begin
      val_clamped = BAL_MAX;
    end else begin
      val_clamped = new_val[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      blocked_r     <= push;
      woken_valid_r <= pop;
      woken_id_r    <= pop ? PID_W'(rd_data_r) : '0;
      error_r       <= err;
      value_r       <= val_clamped;
    end
  end

  assign out_blocked         = blocked_r;
  assign out_woken_valid     = woken_valid_r;
  assign out_woken_id        = woken_id_r;
  assign out_error_flag      = error_r;
  assign out_semaphore_value = value_r;

endmodule

>>> sv/counting_semaphore_fifo_wait_unit.sv
// top level of the counting semaphore with fifo wait queue
// depends on csfw_pkg, csfw_ctrl, csfw_dp
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | in_command, in_process_id
//   out     | out_valid / out_stall| out_blocked, out_woken_valid, out_woken_id,
//           |                      | out_error_flag, out_semaphore_value
//   cfg     | cfg_wr_en            | cfg_wr_data (initial value)
//
// an item is taken in ST_IDLE, where the ring head is read, then executed in ST_EXEC,
// which loads the output register; a new item is taken while the result waits
// reset is synchronous, active low: balance, queue pointers and count clear,
// initial value returns to 1; ring contents are not cleared
// a stalled output holds the item in execution until the result register frees
module counting_semaphore_fifo_wait_unit
  import csfw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [INIT_W-1:0]       cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [PID_W-1:0]        in_process_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_blocked,
  output logic                    out_woken_valid,
  output logic [PID_W-1:0]        out_woken_id,
  output logic                    out_error_flag,
  output logic signed [VAL_W-1:0] out_semaphore_value
);

  dp_cmd_t dp_cmd;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  csfw_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .dp_cmd              (dp_cmd),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_command          (in_command),
    .in_process_id       (in_process_id),
    .out_blocked         (out_blocked),
    .out_woken_valid     (out_woken_valid),
    .out_woken_id        (out_woken_id),
    .out_error_flag      (out_error_flag),
    .out_semaphore_value (out_semaphore_value)
  );

endmodule

>>> sv/csfw_checker.sv
// port-level checks for the semaphore unit, bound to the top level
// depends on csfw_pkg and counting_semaphore_fifo_wait_unit
module csfw_checker
  import csfw_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_blocked,
  input logic                    out_woken_valid,
  input logic [PID_W-1:0]        out_woken_id,
  input logic                    out_error_flag,
  input logic signed [VAL_W-1:0] out_semaphore_value
);

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_blocked && out_woken_valid) && !(out_blocked && out_error_flag)
                  && !(out_woken_valid && out_error_flag))
    else $error("item reports more than one outcome");

  a_no_wake_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid |-> out_woken_id == '0)
    else $error("woken id set without a wake");

  a_blocked_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_blocked || out_woken_valid) |-> out_semaphore_value[VAL_W-1]
                                                     || out_semaphore_value == '0)
    else $error("block or wake with a positive value");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_semaphore_value)
                               && $stable(out_woken_id))
    else $error("stalled item changed");

endmodule

bind counting_semaphore_fifo_wait_unit csfw_checker u_csfw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_blocked         (out_blocked),
  .out_woken_valid     (out_woken_valid),
  .out_woken_id        (out_woken_id),
  .out_error_flag      (out_error_flag),
  .out_semaphore_value (out_semaphore_value)
);
